// ===== design/speed_gauge_smoother_assert.svh =====
// Assertion macros shared by the speed gauge smoother modules.
// Define ASSERT_OFF to compile the checks away.
`ifndef SPEED_GAUGE_SMOOTHER_ASSERT_SVH
`define SPEED_GAUGE_SMOOTHER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SGS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define SGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SGS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/sgs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sgs_pkg;

  localparam int unsigned SMOOTH_W = 22;
  localparam int unsigned DVD_W    = 32;
  localparam int unsigned DSR_W    = 22;

  localparam logic [13:0] RAW_MAX     = 14'd15984;
  localparam logic [22:0] SNAP_LIMIT  = 23'd204;
  localparam logic [21:0] SMOOTH_MAX  = 22'd4091904;
  localparam logic [8:0]  ANGLE_MIN   = 9'd140;
  localparam logic [8:0]  ANGLE_SPAN  = 9'd260;
  localparam logic [9:0]  NUMBER_MAX  = 10'd999;

  localparam logic [15:0] COLOUR_GREEN = 16'h4EEB;
  localparam logic [15:0] COLOUR_BLUE  = 16'h2D7F;
  localparam logic [15:0] COLOUR_AMBER = 16'hFD20;
  localparam logic [15:0] COLOUR_RED   = 16'hF9E7;

  localparam logic [2:0] CFG_SMOOTH_FACTOR = 3'd0;
  localparam logic [2:0] CFG_BLEND_FACTOR  = 3'd1;
  localparam logic [2:0] CFG_BLINK_THRESH  = 3'd2;
  localparam logic [2:0] CFG_BLINK_PERIOD  = 3'd3;
  localparam logic [2:0] CFG_FULL_SCALE    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SMOOTH,
    ST_SNAP,
    ST_ANG_START,
    ST_ANG_WAIT,
    ST_BLINK_START,
    ST_BLINK_WAIT,
    ST_FINISH
  } sgs_state_t;

  typedef struct packed {
    logic load;
    logic smooth;
    logic snap;
    logic start_ang;
    logic take_ang;
    logic start_blink;
    logic take_blink;
    logic commit;
  } sgs_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic out_free;
  } sgs_sts_t;

  function automatic logic [15:0] zone_colour(input logic [8:0] angle);
    logic [15:0] c;
    begin
      if (angle <= 9'd200) c = COLOUR_GREEN;
      else if (angle <= 9'd264) c = COLOUR_BLUE;
      else if (angle <= 9'd327) c = COLOUR_AMBER;
      else c = COLOUR_RED;
      return c;
    end
  endfunction

  // One colour channel (up to 6 bits) moves toward its target by the rounded
  // scaled gap, and by at least one unit while it has not arrived.
  function automatic logic [5:0] step_channel(input logic [5:0] cur, input logic [5:0] tgt,
                                              input logic [7:0] gain);
    logic        neg;
    logic [5:0]  mag;
    logic [13:0] prod;
    logic [5:0]  q;
    logic [5:0]  res;
    begin
      neg  = tgt < cur;
      mag  = neg ? (cur - tgt) : (tgt - cur);
      prod = 14'(mag) * 14'(gain);
      q    = 6'((15'(prod) + 15'd128) >> 8);
      if (q == 6'd0) q = 6'd1;
      if (mag == 6'd0) res = cur;
      else if (neg) res = cur - q;
      else res = cur + q;
      return res;
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/sgs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sgs_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [sgs_pkg::DVD_W-1:0]   dividend,
  input  wire logic [sgs_pkg::DSR_W-1:0]   divisor,
  output logic                             busy,
  output logic                             done,
  output logic [sgs_pkg::DVD_W-1:0]        quotient
);
  import sgs_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DSR_W-1:0] dsr_r, dsr_nxt;
  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   rem_sub;
  logic             ge;

  // Restoring division, one quotient bit per cycle, dividend bits shift out
  // of the top of the quotient register as quotient bits enter at the bottom.
  assign rem_sh  = {rem_r, q_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};
  assign ge      = rem_sh >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = 5'd0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[DVD_W-2:0], ge};
      rem_nxt = ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

// ===== design/sgs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "speed_gauge_smoother_assert.svh"
module sgs_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sgs_pkg::sgs_cmd_t cmd,
  output sgs_pkg::sgs_sts_t      sts,
  input  wire logic [47:0]       in_tdata,
  input  wire logic              cfg_valid,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [39:0]            out_tdata
);
  import sgs_pkg::*;

  // Configuration registers.
  logic [7:0]  sf_r, bf_r;
  logic [13:0] thr_r;
  logic [15:0] period_r;
  logic [9:0]  fs_r;

  // Item registers and working values.
  logic [15:0]         sample_r;
  logic [31:0]         now_r;
  logic [SMOOTH_W-1:0] s_r, s_nxt;
  logic [8:0]          angle_r;
  logic [15:0]         col_new_r;
  logic                vis_r;

  // Persistent display state.
  logic [15:0] cur_colour_r;
  logic [8:0]  prev_angle_r;
  logic        prev_vis_r;
  logic [9:0]  prev_num_r;
  logic        num_valid_r;

  // Output register.
  logic        out_valid_r;
  logic [8:0]  out_angle_r;
  logic [9:0]  out_num_r;
  logic [15:0] out_colour_r;
  logic        out_vis_r;
  logic        out_redraw_r;

  logic [13:0]         clamped;
  logic [SMOOTH_W-1:0] target;
  logic signed [22:0]  diff;
  logic [SMOOTH_W-1:0] mag;
  logic [29:0]         sm_prod;
  logic [SMOOTH_W-1:0] sm_q;
  logic                snap_hit;
  logic [9:0]          fs_eff;
  logic [15:0]         period_eff;
  logic [DSR_W-1:0]    fsq;
  logic [SMOOTH_W-1:0] sc;
  logic [30:0]         ang_prod;
  logic                div_start;
  logic [DVD_W-1:0]    div_dvd;
  logic [DSR_W-1:0]    div_dsr;
  logic                div_busy, div_done;
  logic [DVD_W-1:0]    div_q;
  logic [15:0]         zone;
  logic [4:0]          r_new, b_new;
  logic [5:0]          g_new;
  logic                below_thr;
  logic [9:0]          whole;
  logic [11:0]         frac;
  logic                round_up;
  logic [10:0]         num_sum;
  logic [9:0]          number;
  logic                redraw;

  assign clamped = sample_r[15] ? 14'd0 :
                   (sample_r > {2'b00, RAW_MAX}) ? RAW_MAX : sample_r[13:0];
  assign target  = {clamped, 8'b0};
  assign diff    = $signed({1'b0, target}) - $signed({1'b0, s_r});
  assign mag     = diff[22] ? SMOOTH_W'(-diff) : diff[SMOOTH_W-1:0];
  assign sm_prod = 30'(mag) * 30'(sf_r);
  assign sm_q    = SMOOTH_W'((sm_prod + 30'd128) >> 8);
  assign snap_hit = (diff <= $signed(SNAP_LIMIT)) && (diff >= -$signed(SNAP_LIMIT));

  // The smoother step never overshoots the target, so the sum stays in range.
  always_comb begin
    s_nxt = s_r;
    if (cmd.smooth) s_nxt = diff[22] ? (s_r - sm_q) : (s_r + sm_q);
    else if (cmd.snap && snap_hit) s_nxt = target;
  end

  assign fs_eff     = (fs_r == 10'd0) ? 10'd1 : fs_r;
  assign period_eff = (period_r == 16'd0) ? 16'd1 : period_r;
  assign fsq        = {fs_eff, 12'b0};
  assign sc         = (s_r < fsq) ? s_r : fsq;
  assign ang_prod   = 31'(sc) * 31'(ANGLE_SPAN);

  assign div_start = cmd.start_ang || cmd.start_blink;
  assign div_dvd   = cmd.start_ang ? {1'b0, ang_prod} : now_r;
  assign div_dsr   = cmd.start_ang ? fsq : {6'b0, period_eff};

  sgs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign zone  = zone_colour(angle_r);
  assign r_new = 5'(step_channel({1'b0, cur_colour_r[15:11]}, {1'b0, zone[15:11]}, bf_r));
  assign g_new = step_channel(cur_colour_r[10:5], zone[10:5], bf_r);
  assign b_new = 5'(step_channel({1'b0, cur_colour_r[4:0]}, {1'b0, zone[4:0]}, bf_r));

  assign below_thr = $signed({sample_r[15], sample_r}) <= $signed({3'b000, thr_r});

  // Whole km/h, rounded half to even.
  assign whole    = s_r[21:12];
  assign frac     = s_r[11:0];
  assign round_up = (frac > 12'd2048) || ((frac == 12'd2048) && whole[0]);
  assign num_sum  = {1'b0, whole} + {10'b0, round_up};
  assign number   = (num_sum > {1'b0, NUMBER_MAX}) ? NUMBER_MAX : num_sum[9:0];

  assign redraw = (angle_r != prev_angle_r) || !num_valid_r || (number != prev_num_r) ||
                  (col_new_r != cur_colour_r) || (vis_r != prev_vis_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r         <= 8'd56;
      bf_r         <= 8'd46;
      thr_r        <= 14'd1440;
      period_r     <= 16'd300;
      fs_r         <= 10'd150;
      s_r          <= '0;
      cur_colour_r <= COLOUR_GREEN;
      prev_angle_r <= ANGLE_MIN;
      prev_vis_r   <= 1'b1;
      prev_num_r   <= 10'd0;
      num_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SMOOTH_FACTOR: sf_r     <= cfg_data[7:0];
          CFG_BLEND_FACTOR:  bf_r     <= cfg_data[7:0];
          CFG_BLINK_THRESH:  thr_r    <= cfg_data[13:0];
          CFG_BLINK_PERIOD:  period_r <= cfg_data;
          CFG_FULL_SCALE:    fs_r     <= cfg_data[9:0];
          default: ;
        endcase
      end
      s_r <= s_nxt;
      if (cmd.commit) begin
        cur_colour_r <= col_new_r;
        prev_angle_r <= angle_r;
        prev_vis_r   <= vis_r;
        prev_num_r   <= number;
        num_valid_r  <= 1'b1;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_tdata[15:0];
      now_r    <= in_tdata[47:16];
    end
    if (cmd.take_ang) angle_r <= ANGLE_MIN + div_q[8:0];
    if (cmd.start_blink) col_new_r <= {r_new, g_new, b_new};
    if (cmd.take_blink) vis_r <= below_thr || !div_q[0];
    if (cmd.commit) begin
      out_angle_r  <= angle_r;
      out_num_r    <= number;
      out_colour_r <= col_new_r;
      out_vis_r    <= vis_r;
      out_redraw_r <= redraw;
    end
  end

  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_redraw_r, out_vis_r, out_colour_r, out_num_r, out_angle_r};

  `SGS_ASSERT_IMPL(a_smooth_range, clk, rst_n, 1'b1, s_r <= SMOOTH_MAX)
  `SGS_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, out_valid_r && num_valid_r)
  `SGS_ASSERT_IMPL(a_angle_range, clk, rst_n, num_valid_r, prev_angle_r <= ANGLE_MIN + ANGLE_SPAN)
endmodule
`default_nettype wire

// ===== design/sgs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "speed_gauge_smoother_assert.svh"
module sgs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire sgs_pkg::sgs_sts_t sts,
  output sgs_pkg::sgs_cmd_t      cmd
);
  import sgs_pkg::*;

  sgs_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:        if (in_tvalid) state_nxt = ST_SMOOTH;
      ST_SMOOTH:      state_nxt = ST_SNAP;
      ST_SNAP:        state_nxt = ST_ANG_START;
      ST_ANG_START:   state_nxt = ST_ANG_WAIT;
      ST_ANG_WAIT:    if (sts.div_done) state_nxt = ST_BLINK_START;
      ST_BLINK_START: state_nxt = ST_BLINK_WAIT;
      ST_BLINK_WAIT:  if (sts.div_done) state_nxt = ST_FINISH;
      ST_FINISH:      if (sts.out_free) state_nxt = ST_IDLE;
      default:        state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SMOOTH:      cmd.smooth      = 1'b1;
      ST_SNAP:        cmd.snap        = 1'b1;
      ST_ANG_START:   cmd.start_ang   = 1'b1;
      ST_ANG_WAIT:    cmd.take_ang    = sts.div_done;
      ST_BLINK_START: cmd.start_blink = 1'b1;
      ST_BLINK_WAIT:  cmd.take_blink  = sts.div_done;
      ST_FINISH:      cmd.commit      = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  `SGS_ASSERT_IMPL(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd))
  `SGS_ASSERT_IMPL(a_commit_free, clk, rst_n, cmd.commit, sts.out_free)
  `SGS_ASSERT_IMPL(a_start_idle_div, clk, rst_n, cmd.start_ang || cmd.start_blink, !sts.div_busy)
endmodule
`default_nettype wire

// ===== design/speed_gauge_smoother.sv =====
// An accepted request passes the smooth and snap steps, then two 32-step passes of the
// shared radix-2 divider (needle angle, then blink phase), and is committed to the output
// register once that register is free; the next request is taken only after the commit.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n low, synchronous) restores register defaults, a zero smoothed speed,
// green digits and forces a redraw on the first result.
`timescale 1ns / 1ps
`default_nettype none
module speed_gauge_smoother (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // speed_sample[15:0], now_ms[47:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // gauge_angle[8:0], shown_speed[18:9],
                                       // speed_colour[34:19], speed_visible[35],
                                       // redraw[36], zero[39:37]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import sgs_pkg::*;

  sgs_cmd_t cmd;
  sgs_sts_t sts;

  assign cfg_ready = 1'b1;

  sgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sgs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import sgs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [8:0]  angle;
    logic [9:0]  number;
    logic [15:0] colour;
    logic        visible;
    logic        redraw;
  } gauge_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;    // speed_sample[15:0], now_ms[47:16]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;   // gauge_angle[8:0], shown_speed[18:9], speed_colour[34:19],
                            // speed_visible[35], redraw[36], zero[39:37]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // Register copies used by the predictor.
  logic [7:0]  gain_smooth;
  logic [7:0]  gain_blend;
  logic [13:0] blink_level;
  logic [15:0] blink_half_ms;
  logic [9:0]  full_scale_kmh;

  // Gauge state as the predictor sees it.
  logic [21:0] smoothed_q12;
  logic [15:0] shown_colour;
  logic [8:0]  last_angle;
  logic        last_visible;
  logic [9:0]  last_number;
  logic        number_shown;

  gauge_result_t pending_results[$];

  int  error_count;
  int  results_checked;
  int  samples_sent;
  int  settings_used;
  int  cycle_count;
  bit  no_gaps;
  int  road_speed;
  logic [31:0] dash_ms;

  speed_gauge_smoother dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Rounded delta * gain / 256, ties away from zero.
  function automatic longint round_gain(input longint delta, input int unsigned gain);
    longint mag;
    longint q;
    mag = (delta < 0 ? -delta : delta) * longint'(gain);
    q = (mag + 128) >>> 8;
    return delta < 0 ? -q : q;
  endfunction

  function automatic int channel_step(input int cur, input int tgt, input int unsigned gain);
    longint delta;
    longint step;
    delta = longint'(tgt) - longint'(cur);
    if (delta == 0) return cur;
    step = round_gain(delta, gain);
    if (step == 0) step = delta > 0 ? 1 : -1;
    return int'(longint'(cur) + step);
  endfunction

  function automatic logic [15:0] zone_target(input logic [8:0] angle);
    if (angle <= 9'd200) return COLOUR_GREEN;
    if (angle <= 9'd264) return COLOUR_BLUE;
    if (angle <= 9'd327) return COLOUR_AMBER;
    return COLOUR_RED;
  endfunction

  function automatic gauge_result_t predict_gauge(input logic [15:0] raw, input logic [31:0] now);
    int                sample;
    int                clamped;
    longint            target;
    longint            s;
    longint            diff;
    int unsigned       whole;
    int unsigned       frac;
    int unsigned       number;
    int unsigned       fs;
    int unsigned       period;
    longint unsigned   fsq;
    longint unsigned   sc;
    logic [8:0]        angle;
    logic [15:0]       zone;
    logic [15:0]       next_colour;
    int                r;
    int                g;
    int                b;
    logic              vis;
    gauge_result_t     res;
    sample = int'($signed(raw));
    clamped = sample < 0 ? 0 : (sample > int'(RAW_MAX) ? int'(RAW_MAX) : sample);
    target = longint'(clamped) * 256;
    s = longint'(smoothed_q12);
    s += round_gain(target - s, gain_smooth);
    diff = target - s;
    if (diff <= longint'(SNAP_LIMIT) && diff >= -longint'(SNAP_LIMIT)) s = target;
    if (s < 0) s = 0;
    smoothed_q12 = s[21:0];

    whole = smoothed_q12 >> 12;
    frac = smoothed_q12 & 22'hFFF;
    number = whole;
    if (frac > 2048 || (frac == 2048 && whole[0])) number = whole + 1;
    if (number > 999) number = 999;

    fs = full_scale_kmh == 0 ? 1 : full_scale_kmh;
    fsq = longint'(fs) << 12;
    sc = smoothed_q12 < fsq ? smoothed_q12 : fsq;
    angle = 9'(140 + (sc * 260) / fsq);

    zone = zone_target(angle);
    r = channel_step(int'(shown_colour[15:11]), int'(zone[15:11]), gain_blend);
    g = channel_step(int'(shown_colour[10:5]), int'(zone[10:5]), gain_blend);
    b = channel_step(int'(shown_colour[4:0]), int'(zone[4:0]), gain_blend);
    next_colour = {r[4:0], g[5:0], b[4:0]};

    period = blink_half_ms == 0 ? 1 : blink_half_ms;
    vis = (sample <= int'(blink_level)) || (((now / period) & 1) == 0);

    res.angle = angle;
    res.number = number[9:0];
    res.colour = next_colour;
    res.visible = vis;
    res.redraw = angle != last_angle || !number_shown || number[9:0] != last_number ||
                 next_colour != shown_colour || vis != last_visible;

    last_angle = angle;
    last_number = number[9:0];
    number_shown = 1'b1;
    shown_colour = next_colour;
    last_visible = vis;
    return res;
  endfunction

  // Sends one speed request and records what the gauge should show for it.
  task automatic send_sample(input logic [15:0] raw, input logic [31:0] now);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {now, raw};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_gauge(raw, now));
    samples_sent++;
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SMOOTH_FACTOR: gain_smooth = value[7:0];
      CFG_BLEND_FACTOR:  gain_blend = value[7:0];
      CFG_BLINK_THRESH:  blink_level = value[13:0];
      CFG_BLINK_PERIOD:  blink_half_ms = value;
      CFG_FULL_SCALE:    full_scale_kmh = value[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input int sf, input int bf, input int th, input int per,
                                input int fs);
    write_reg(CFG_SMOOTH_FACTOR, 16'(sf));
    write_reg(CFG_BLEND_FACTOR, 16'(bf));
    write_reg(CFG_BLINK_THRESH, 16'(th));
    write_reg(CFG_BLINK_PERIOD, 16'(per));
    write_reg(CFG_FULL_SCALE, 16'(fs));
    settings_used++;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Result checker: every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    gauge_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("gauge_angle", want.angle, out_tdata[8:0]);
        check_field("shown_speed", want.number, out_tdata[18:9]);
        check_field("speed_colour", want.colour, out_tdata[34:19]);
        check_field("speed_visible", want.visible, out_tdata[35]);
        check_field("redraw", want.redraw, out_tdata[36]);
        results_checked++;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= !rst_n || no_gaps || $urandom_range(99) >= 6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Opening the dashboard: first frame redraws, and the edges of every field.
  task automatic test_reset_defaults();
    send_sample(16'd0, 32'd0);
    send_sample(16'd0, 32'd1);
    send_sample(16'h7FFF, 32'd0);
    send_sample(16'h8000, 32'hFFFF_FFFF);
    send_sample(16'hFFFF, 32'd300);
    send_sample(16'd1441, 32'd300);
    send_sample(16'd1440, 32'd300);
    send_sample(16'd1441, 32'd600);
    send_sample(16'd15984, 32'hFFFF_FFFF);
    send_sample(16'd15985, 32'd899);
    send_sample(16'd8, 32'd1000);
    send_sample(16'd24, 32'd1000);
    end_burst();
    wait_drained();
  endtask

  // Zero gains, zero period and zero or oversize full scale, then the opposite corners.
  task automatic test_register_corners();
    apply_settings(0, 0, 0, 0, 0);
    send_sample(16'd1600, 32'd1);
    send_sample(16'd1600, 32'd2);
    send_sample(16'd0, 32'd3);
    send_sample(16'd16, 32'd4);
    end_burst();
    wait_drained();
    apply_settings(255, 255, 16383, 65535, 1023);
    send_sample(16'h7FFF, 32'd65535);
    send_sample(16'h7FFF, 32'd65536);
    send_sample(16'd15984, 32'd131071);
    send_sample(16'h8000, 32'd0);
    end_burst();
    wait_drained();
    apply_settings(1, 1, 0, 1, 1);
    send_sample(16'd16, 32'd0);
    send_sample(16'd16, 32'd1);
    send_sample(16'd0, 32'd5);
    end_burst();
    wait_drained();
  endtask

  // Mostly realistic driving: ramps, steady cruising and sudden jumps, with some noise.
  task automatic run_drive_phase(input int count);
    int i;
    int k;
    int run_len;
    int pick;
    i = 0;
    while (i < count) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        run_len = $urandom_range(3, 20);
        for (k = 0; k < run_len && i < count; k++) begin
          road_speed += $urandom_range(0, 400) - 200;
          if (road_speed < 0) road_speed = 0;
          if (road_speed > 16383) road_speed = 16383;
          dash_ms += $urandom_range(5, 250);
          send_sample(16'(road_speed), dash_ms);
          i++;
        end
      end else if (pick < 75) begin
        run_len = $urandom_range(5, 40);
        for (k = 0; k < run_len && i < count; k++) begin
          dash_ms += $urandom_range(1, 120);
          send_sample(16'(road_speed), dash_ms);
          i++;
        end
      end else if (pick < 85) begin
        road_speed = $urandom_range(3) == 0 ? $urandom_range(0, 16383) : $urandom_range(0, 4800);
        dash_ms += $urandom_range(5, 250);
        send_sample(16'(road_speed), dash_ms);
        i++;
      end else begin
        if ($urandom_range(3) == 0) dash_ms = $urandom();
        send_sample(16'($urandom()), $urandom());
        i++;
      end
    end
    end_burst();
    wait_drained();
  endtask

  task automatic test_random_driving();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_settings(56, 46, 1440, 300, 150);
        1: apply_settings(255, 255, 0, 1, 1);
        2: apply_settings(1, 1, 16383, 65535, 999);
        default: apply_settings($urandom_range(1, 255), $urandom_range(1, 255),
                                $urandom_range(0, 16383),
                                $urandom_range(1) ? $urandom_range(1, 2000)
                                                  : $urandom_range(1, 65535),
                                $urandom_range(1, 1023));
      endcase
      // One phase runs with both sides at full rate.
      no_gaps = phase == 4;
      run_drive_phase(130);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SMOOTH_FACTOR;
    cfg_data = '0;
    error_count = 0;
    results_checked = 0;
    samples_sent = 0;
    settings_used = 1;
    cycle_count = 0;
    no_gaps = 1'b0;
    road_speed = 0;
    dash_ms = 32'd0;

    gain_smooth = 8'd56;
    gain_blend = 8'd46;
    blink_level = 14'd1440;
    blink_half_ms = 16'd300;
    full_scale_kmh = 10'd150;
    smoothed_q12 = '0;
    shown_colour = COLOUR_GREEN;
    last_angle = ANGLE_MIN;
    last_visible = 1'b1;
    last_number = '0;
    number_shown = 1'b0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_register_corners();
    test_random_driving();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d speed samples under %0d register settings, checked %0d results.",
             samples_sent, settings_used, results_checked);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results never arrived", error_count,
               pending_results.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
